### src/mrlm_pkg.sv
// ----------------------------------------------------------------------------
// mrlm_pkg: shared definitions for the modem response line matcher
// Beat layouts, field codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package mrlm_pkg;

    // Line store and recent-character window sizing.
    localparam int LINE_MAX    = 64;
    localparam int LINE_AW     = $clog2(LINE_MAX);
    localparam int PATTERN_MAX = 16;
    localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W      = $clog2(PATTERN_MAX);

    // Configuration port sizing.
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    // Register indexes (paddr divided by eight).
    localparam logic [2:0] REG_TERMINATOR     = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd1;
    localparam logic [2:0] REG_GAP_TICKS      = 3'd2;
    localparam logic [2:0] REG_PATTERN_LOW    = 3'd3;
    localparam logic [2:0] REG_PATTERN_HIGH   = 3'd4;
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd5;

    // Character constants.
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_K  = 8'h4B;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_R  = 8'h52;

    localparam logic [7:0] GAP_SAT = 8'hFF;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OUTCOME_TIMEOUT = 2'd0,
        OUTCOME_PATTERN = 2'd1,
        OUTCOME_OK      = 2'd2,
        OUTCOME_ERROR   = 2'd3
    } outcome_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        outcome_t   outcome;
        logic [7:0] line_char;
        logic       line_empty;
        logic       last;
    } out_item_t;

endpackage

### src/mrlm_ram.sv
// ----------------------------------------------------------------------------
// mrlm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/modem_response_line_matcher.sv
// ----------------------------------------------------------------------------
// modem_response_line_matcher: waits for a modem reply line
// Gathers received bytes into lines, matches each closed line against an
// expected pattern, OK and ERROR, and plays out the final line on a match
// or on timeout.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                  | Beat
//  item     | in        | item_valid / item_ready    | in_item_t  (kind, rx_byte)
//  result   | out       | result_valid / result_ready| out_item_t (one line char)
//  config   | in        | APB psel/penable/pwrite    | 64-bit register, addr 8*i
//
// Each item beat is registered in the item stage and processed from there; a
// new item is taken every cycle while no line is being played out.
// An item that ends the wait starts a run of max(1, line length) result
// beats, one per cycle while result_ready is high, read from the line store
// RAM; the item stage holds during the run.
// Result stalls hold the current beat; the store read address is held too.
// Reset is asynchronous; the line store has no reset and needs no clear.
// ----------------------------------------------------------------------------
module modem_response_line_matcher (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  mrlm_pkg::in_item_t       item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output mrlm_pkg::out_item_t      result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [mrlm_pkg::CFG_AW-1:0] paddr,
    input  logic [mrlm_pkg::CFG_DW-1:0] pwdata,
    output logic [mrlm_pkg::CFG_DW-1:0] prdata,
    output logic                     pready
);

    import mrlm_pkg::*;

    // Configuration registers.
    logic [7:0]  terminator_reg,     terminator_next;
    logic [31:0] timeout_ticks_reg,  timeout_ticks_next;
    logic [7:0]  gap_ticks_reg,      gap_ticks_next;
    logic [63:0] pattern_low_reg,    pattern_low_next;
    logic [63:0] pattern_high_reg,   pattern_high_next;
    logic [4:0]  pattern_length_reg, pattern_length_next;

    // Item stage.
    logic        stage_full_reg, stage_full_next;
    in_item_t    stage_reg;

    // Wait and line state.
    logic [LINE_AW-1:0] line_count_reg, line_count_next;
    logic [7:0]         win_reg [PATTERN_MAX];
    logic [7:0]         win_new [PATTERN_MAX];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               pat_seen_reg, pat_seen_next;
    logic               ok_seen_reg, ok_seen_next;
    logic               err_seen_reg, err_seen_next;
    logic               waiting_reg, waiting_next;
    logic               line_open_reg, line_open_next;
    logic [7:0]         gap_count_reg, gap_count_next;
    logic [31:0]        wait_count_reg, wait_count_next;
    logic               win_shift;

    // Playout run.
    logic               run_active_reg, run_active_next;
    outcome_t           run_outcome_reg, run_outcome_next;
    logic               run_empty_reg, run_empty_next;
    logic [LINE_AW-1:0] run_last_reg, run_last_next;
    logic [LINE_AW-1:0] rd_idx_reg, rd_idx_next;

    // Line store port.
    logic               ram_we;
    logic [LINE_AW-1:0] ram_waddr;
    logic [7:0]         ram_rdata;

    // Matching helpers.
    logic [127:0]       pattern_all;
    logic [7:0]         pat_chars [PATTERN_MAX];
    logic [FILL_W-1:0]  plen;
    logic [LINE_AW-1:0] cur_count;
    logic [FILL_W-1:0]  cur_fill;
    logic [FILL_W-1:0]  fill_new;
    logic               cur_pat, cur_ok, cur_err;
    logic               pat_hit, ok_hit, err_hit;
    logic               advance, item_fire, cfg_write;
    logic [2:0]         cfg_idx;
    logic [7:0]         gap_eff;

    assign advance    = stage_full_reg && !run_active_reg;
    assign item_ready = !stage_full_reg || !run_active_reg;
    assign item_fire  = item_valid && item_ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign cfg_idx    = paddr[5:3];

    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign plen = (pattern_length_reg > 5'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX)
                                                         : FILL_W'(pattern_length_reg);
    assign gap_eff = (gap_ticks_reg == 8'd0) ? 8'd1 : gap_ticks_reg;

    // A newly opened line starts from an empty count, window and flag set.
    assign cur_count = line_open_reg ? line_count_reg : '0;
    assign cur_fill  = line_open_reg ? fill_reg : '0;
    assign cur_pat   = line_open_reg && pat_seen_reg;
    assign cur_ok    = line_open_reg && ok_seen_reg;
    assign cur_err   = line_open_reg && err_seen_reg;
    assign fill_new  = (cur_fill == FILL_W'(PATTERN_MAX)) ? cur_fill : cur_fill + 1'b1;

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_chars[i] = pattern_all[8*i +: 8];
        end
        win_new[0] = stage_reg.rx_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            win_new[i] = win_reg[i-1];
        end
    end

    // Suffix checks on the window as it stands after the new char goes in.
    // The newest char is at age zero; pattern char i pairs with age plen-1-i.
    always_comb
    begin
        logic              mism;
        logic [PIDX_W-1:0] pidx;
        mism = 1'b0;
        pidx = '0;
        for (int a = 0; a < PATTERN_MAX; a++)
        begin
            if (FILL_W'(a) < plen)
            begin
                pidx = PIDX_W'(plen - FILL_W'(a + 1));
                if (win_new[a] != pat_chars[pidx])
                begin
                    mism = 1'b1;
                end
            end
        end
        pat_hit = (plen > FILL_W'(1)) && (plen <= fill_new) && !mism;
        ok_hit  = (fill_new >= FILL_W'(2)) && (win_new[1] == CHAR_O)
                  && (win_new[0] == CHAR_K);
        err_hit = (fill_new >= FILL_W'(5)) && (win_new[4] == CHAR_E)
                  && (win_new[3] == CHAR_R) && (win_new[2] == CHAR_R)
                  && (win_new[1] == CHAR_O) && (win_new[0] == CHAR_R);
    end

    // Item processing and playout sequencing.
    always_comb
    begin
        logic     finish;
        logic     emit_now;
        outcome_t emit_code;

        finish    = 1'b0;
        emit_now  = 1'b0;
        emit_code = OUTCOME_TIMEOUT;

        stage_full_next  = stage_full_reg;
        line_count_next  = line_count_reg;
        fill_next        = fill_reg;
        pat_seen_next    = pat_seen_reg;
        ok_seen_next     = ok_seen_reg;
        err_seen_next    = err_seen_reg;
        waiting_next     = waiting_reg;
        line_open_next   = line_open_reg;
        gap_count_next   = gap_count_reg;
        wait_count_next  = wait_count_reg;
        win_shift        = 1'b0;
        run_active_next  = run_active_reg;
        run_outcome_next = run_outcome_reg;
        run_empty_next   = run_empty_reg;
        run_last_next    = run_last_reg;
        rd_idx_next      = rd_idx_reg;
        ram_we           = 1'b0;
        ram_waddr        = cur_count;

        if (item_fire)
        begin
            stage_full_next = 1'b1;
        end
        else if (advance)
        begin
            stage_full_next = 1'b0;
        end

        if (advance)
        begin
            case (stage_reg.kind)
                KIND_START:
                begin
                    waiting_next    = 1'b1;
                    line_open_next  = 1'b0;
                    line_count_next = '0;
                    fill_next       = '0;
                    pat_seen_next   = 1'b0;
                    ok_seen_next    = 1'b0;
                    err_seen_next   = 1'b0;
                    gap_count_next  = '0;
                    wait_count_next = '0;
                end
                KIND_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        line_open_next  = 1'b1;
                        line_count_next = cur_count;
                        fill_next       = cur_fill;
                        pat_seen_next   = cur_pat;
                        ok_seen_next    = cur_ok;
                        err_seen_next   = cur_err;
                        gap_count_next  = line_open_reg ? gap_count_reg : 8'd0;
                        if (stage_reg.rx_byte == terminator_reg)
                        begin
                            finish = 1'b1;
                        end
                        else if (stage_reg.rx_byte != CHAR_LF
                                 && stage_reg.rx_byte != CHAR_CR)
                        begin
                            gap_count_next = 8'd0;
                            if (cur_count == LINE_AW'(LINE_MAX - 1))
                            begin
                                // Line count at its limit: the byte is dropped and the line closes.
                                finish = 1'b1;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                line_count_next = cur_count + 1'b1;
                                win_shift       = 1'b1;
                                fill_next       = fill_new;
                                pat_seen_next   = cur_pat || pat_hit;
                                ok_seen_next    = cur_ok || ok_hit;
                                err_seen_next   = cur_err || err_hit;
                            end
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (waiting_reg)
                    begin
                        if (wait_count_reg != 32'hFFFF_FFFF)
                        begin
                            wait_count_next = wait_count_reg + 1'b1;
                        end
                        if (line_open_reg)
                        begin
                            if (gap_count_reg != GAP_SAT)
                            begin
                                gap_count_next = gap_count_reg + 1'b1;
                            end
                            if (gap_count_next >= gap_eff)
                            begin
                                finish = 1'b1;
                            end
                        end
                        else if (wait_count_next >= timeout_ticks_reg)
                        begin
                            emit_now = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (finish)
            begin
                line_open_next = 1'b0;
                if (cur_count != '0 && plen > FILL_W'(1) && pat_seen_next)
                begin
                    emit_now  = 1'b1;
                    emit_code = OUTCOME_PATTERN;
                end
                else if (cur_count != '0 && ok_seen_next)
                begin
                    emit_now  = 1'b1;
                    emit_code = OUTCOME_OK;
                end
                else if (cur_count != '0 && err_seen_next)
                begin
                    emit_now  = 1'b1;
                    emit_code = OUTCOME_ERROR;
                end
                else if (wait_count_next >= timeout_ticks_reg)
                begin
                    emit_now = 1'b1;
                end
            end

            if (emit_now)
            begin
                waiting_next     = 1'b0;
                line_open_next   = 1'b0;
                run_active_next  = 1'b1;
                run_outcome_next = emit_code;
                run_empty_next   = (line_count_next == '0);
                run_last_next    = line_count_next - 1'b1;
                rd_idx_next      = '0;
            end
        end
        else if (run_active_reg && result_ready)
        begin
            if (run_empty_reg || rd_idx_reg == run_last_reg)
            begin
                run_active_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end
    end

    // Configuration writes and reads.
    always_comb
    begin
        terminator_next     = terminator_reg;
        timeout_ticks_next  = timeout_ticks_reg;
        gap_ticks_next      = gap_ticks_reg;
        pattern_low_next    = pattern_low_reg;
        pattern_high_next   = pattern_high_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_TERMINATOR:     terminator_next     = pwdata[7:0];
                REG_TIMEOUT_TICKS:  timeout_ticks_next  = pwdata[31:0];
                REG_GAP_TICKS:      gap_ticks_next      = pwdata[7:0];
                REG_PATTERN_LOW:    pattern_low_next    = pwdata;
                REG_PATTERN_HIGH:   pattern_high_next   = pwdata;
                REG_PATTERN_LENGTH: pattern_length_next = pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TERMINATOR:     prdata = {56'd0, terminator_reg};
            REG_TIMEOUT_TICKS:  prdata = {32'd0, timeout_ticks_reg};
            REG_GAP_TICKS:      prdata = {56'd0, gap_ticks_reg};
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg     <= 8'd10;
            timeout_ticks_reg  <= 32'd1000;
            gap_ticks_reg      <= 8'd5;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            stage_full_reg     <= 1'b0;
            line_count_reg     <= '0;
            fill_reg           <= '0;
            pat_seen_reg       <= 1'b0;
            ok_seen_reg        <= 1'b0;
            err_seen_reg       <= 1'b0;
            waiting_reg        <= 1'b0;
            line_open_reg      <= 1'b0;
            gap_count_reg      <= '0;
            wait_count_reg     <= '0;
            run_active_reg     <= 1'b0;
            run_outcome_reg    <= OUTCOME_TIMEOUT;
            run_empty_reg      <= 1'b0;
            run_last_reg       <= '0;
            rd_idx_reg         <= '0;
        end
        else
        begin
            terminator_reg     <= terminator_next;
            timeout_ticks_reg  <= timeout_ticks_next;
            gap_ticks_reg      <= gap_ticks_next;
            pattern_low_reg    <= pattern_low_next;
            pattern_high_reg   <= pattern_high_next;
            pattern_length_reg <= pattern_length_next;
            stage_full_reg     <= stage_full_next;
            line_count_reg     <= line_count_next;
            fill_reg           <= fill_next;
            pat_seen_reg       <= pat_seen_next;
            ok_seen_reg        <= ok_seen_next;
            err_seen_reg       <= err_seen_next;
            waiting_reg        <= waiting_next;
            line_open_reg      <= line_open_next;
            gap_count_reg      <= gap_count_next;
            wait_count_reg     <= wait_count_next;
            run_active_reg     <= run_active_next;
            run_outcome_reg    <= run_outcome_next;
            run_empty_reg      <= run_empty_next;
            run_last_reg       <= run_last_next;
            rd_idx_reg         <= rd_idx_next;
        end
    end

    // Payload registers: the item stage and the char window.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            stage_reg <= item;
        end
        if (win_shift)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                win_reg[i] <= win_new[i];
            end
        end
    end

    // The read address follows the next index, so the registered read data
    // always matches the current playout index.
    mrlm_ram #(
        .WIDTH(8),
        .DEPTH(LINE_MAX)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stage_reg.rx_byte),
        .raddr (rd_idx_next),
        .rdata (ram_rdata)
    );

    assign result_valid      = run_active_reg;
    assign result.outcome    = run_outcome_reg;
    assign result.line_char  = run_empty_reg ? 8'd0 : ram_rdata;
    assign result.line_empty = run_empty_reg;
    assign result.last       = run_empty_reg || (rd_idx_reg == run_last_reg);

endmodule

### tb/tb_modem_response_line_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modem_response_line_matcher: self-checking bench for the reply matcher
// Sends start, byte and tick beats with random idle bursts on both channels,
// follows every accepted beat with a software copy of the matcher, and checks
// each played-out line character beat against it. The configuration is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_modem_response_line_matcher;
    import mrlm_pkg::*;

    // Kind code that the block has no use for.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    class reply_scoreboard;
        logic [7:0]  term_byte;
        logic [31:0] limit_ticks;
        logic [7:0]  gap_limit;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [4:0]  pat_len;

        logic [7:0]  line_buf [LINE_MAX];
        int unsigned line_len;
        logic [7:0]  tail [PATTERN_MAX];
        int unsigned tail_fill;
        bit          saw_pattern;
        bit          saw_ok;
        bit          saw_error;
        bit          in_wait;
        bit          in_line;
        int unsigned idle_ticks;
        logic [31:0] wait_ticks;

        out_item_t   expected_chars[$];
        int unsigned errors;
        int unsigned live_items;

        function new();
            term_byte   = 8'd10;
            limit_ticks = 32'd1000;
            gap_limit   = 8'd5;
            pat_lo      = '0;
            pat_hi      = '0;
            pat_len     = '0;
            in_wait     = 1'b0;
            in_line     = 1'b0;
            wait_ticks  = '0;
            errors      = 0;
            live_items  = 0;
            clear_line();
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_TERMINATOR:     term_byte = val[7:0];
                REG_TIMEOUT_TICKS:  limit_ticks = val[31:0];
                REG_GAP_TICKS:      gap_limit = val[7:0];
                REG_PATTERN_LOW:    pat_lo = val;
                REG_PATTERN_HIGH:   pat_hi = val;
                REG_PATTERN_LENGTH: pat_len = val[4:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int i);
            if (i < 8)
                return pat_lo[8*i +: 8];
            return pat_hi[8*(i-8) +: 8];
        endfunction

        function int pattern_size();
            if (pat_len > PATTERN_MAX)
                return PATTERN_MAX;
            return int'(pat_len);
        endfunction

        function bit tail_is_pattern(int n);
            if (n == 0 || n > tail_fill)
                return 1'b0;
            for (int i = 0; i < n; i++)
                if (tail[n-1-i] != pattern_byte(i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit tail_is_text(string s);
            int n;
            n = s.len();
            if (n > tail_fill)
                return 1'b0;
            for (int i = 0; i < n; i++)
                if (tail[n-1-i] != s[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void clear_line();
            line_len    = 0;
            tail_fill   = 0;
            for (int i = 0; i < PATTERN_MAX; i++)
                tail[i] = '0;
            saw_pattern = 1'b0;
            saw_ok      = 1'b0;
            saw_error   = 1'b0;
            idle_ticks  = 0;
        endfunction

        function void store_byte(logic [7:0] b);
            line_buf[line_len] = b;
            line_len++;
            for (int i = PATTERN_MAX - 1; i > 0; i--)
                tail[i] = tail[i-1];
            tail[0] = b;
            if (tail_fill < PATTERN_MAX)
                tail_fill++;
            if (pattern_size() > 1 && tail_is_pattern(pattern_size()))
                saw_pattern = 1'b1;
            if (tail_is_text("OK"))
                saw_ok = 1'b1;
            if (tail_is_text("ERROR"))
                saw_error = 1'b1;
        endfunction

        function void play_out(outcome_t oc);
            out_item_t r;
            in_wait = 1'b0;
            in_line = 1'b0;
            r.outcome = oc;
            if (line_len == 0) begin
                r.line_char  = 8'h00;
                r.line_empty = 1'b1;
                r.last       = 1'b1;
                expected_chars.push_back(r);
            end
            else begin
                for (int k = 0; k < line_len; k++) begin
                    r.line_char  = line_buf[k];
                    r.line_empty = 1'b0;
                    r.last       = (k + 1 == line_len);
                    expected_chars.push_back(r);
                end
            end
        endfunction

        function void close_line();
            in_line = 1'b0;
            if (line_len > 0) begin
                if (pattern_size() > 1 && saw_pattern) begin
                    play_out(OUTCOME_PATTERN);
                    return;
                end
                if (saw_ok) begin
                    play_out(OUTCOME_OK);
                    return;
                end
                if (saw_error) begin
                    play_out(OUTCOME_ERROR);
                    return;
                end
            end
            if (wait_ticks >= limit_ticks)
                play_out(OUTCOME_TIMEOUT);
        endfunction

        function void byte_in(logic [7:0] b);
            if (!in_line) begin
                clear_line();
                in_line = 1'b1;
            end
            if (b == term_byte)
                close_line();
            else if (b != CHAR_LF && b != CHAR_CR) begin
                idle_ticks = 0;
                // A byte that would fill the store closes the line and is lost.
                if (line_len + 1 >= LINE_MAX)
                    close_line();
                else
                    store_byte(b);
            end
        endfunction

        function void tick_in();
            int g;
            if (wait_ticks != '1)
                wait_ticks++;
            if (in_line) begin
                g = (gap_limit == 0) ? 1 : int'(gap_limit);
                if (idle_ticks < 255)
                    idle_ticks++;
                if (idle_ticks >= g)
                    close_line();
            end
            else if (wait_ticks >= limit_ticks)
                play_out(OUTCOME_TIMEOUT);
        endfunction

        function void take_item(in_item_t it);
            case (it.kind)
                KIND_START: begin
                    live_items++;
                    in_wait    = 1'b1;
                    in_line    = 1'b0;
                    wait_ticks = '0;
                    clear_line();
                end
                KIND_BYTE: begin
                    if (in_wait) begin
                        live_items++;
                        byte_in(it.rx_byte);
                    end
                end
                KIND_TICK: begin
                    if (in_wait) begin
                        live_items++;
                        tick_in();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result beat: outcome %0d char %02h empty %b last %b",
                             got.outcome, got.line_char, got.line_empty, got.last);
                return;
            end
            want = expected_chars.pop_front();
            if (got.outcome !== want.outcome || got.line_char !== want.line_char ||
                got.line_empty !== want.line_empty || got.last !== want.last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: exp %0d %02h %b %b, got %0d %02h %b %b",
                             want.outcome, want.line_char, want.line_empty, want.last,
                             got.outcome, got.line_char, got.line_empty, got.last);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    in_item_t            item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_item_t           result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    bit                  item_gaps = 1'b1;
    bit                  ready_gaps = 1'b1;
    bit                  quiet = 1'b0;
    int unsigned         quiet_from = 32'hFFFF_FFFF;
    int unsigned         cycles = 0;
    reply_scoreboard     sb;

    modem_response_line_matcher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check every accepted beat, then pick ready for the next edge.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
            if (stall > 0 && !quiet)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else if (ready_gaps && !quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 6) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic drive_item(logic [1:0] k, logic [7:0] b);
        in_item_t it;
        int gap;
        it.kind    = kind_t'(k);
        it.rx_byte = b;
        if (sb.live_items >= quiet_from)
            quiet = 1'b1;
        if (item_gaps && !quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        sb.take_item(it);
    endtask

    // One write, then the bus returns to idle before the next transfer.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Let the line play out and the item stage empty before touching registers.
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] alphabet_char();
        string letters;
        letters = "OKERAT+0";
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    function automatic logic [7:0] line_byte();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return alphabet_char();
        if (p < 6)
            return sb.pattern_byte(int'($urandom_range(0, PATTERN_MAX - 1)));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            drive_item(KIND_BYTE, s[i]);
    endtask

    task automatic send_pattern();
        for (int i = 0; i < sb.pattern_size(); i++)
            drive_item(KIND_BYTE, sb.pattern_byte(i));
    endtask

    task automatic configure(int phase);
        logic [7:0]  pat [PATTERN_MAX];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  term;
        int          pick;
        if (phase == 0)
        begin
            write_reg(REG_TERMINATOR, 64'h00);
            write_reg(REG_TIMEOUT_TICKS, 64'd0);
            write_reg(REG_GAP_TICKS, 64'd1);
            write_reg(REG_PATTERN_LOW, 64'd0);
            write_reg(REG_PATTERN_HIGH, 64'd0);
            write_reg(REG_PATTERN_LENGTH, 64'd0);
        end
        else if (phase == 1)
        begin
            write_reg(REG_TERMINATOR, 64'hFF);
            write_reg(REG_TIMEOUT_TICKS, 64'hFFFF_FFFF);
            write_reg(REG_GAP_TICKS, 64'd255);
            write_reg(REG_PATTERN_LOW, '1);
            write_reg(REG_PATTERN_HIGH, '1);
            write_reg(REG_PATTERN_LENGTH, 64'(PATTERN_MAX));
        end
        else
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                pat[i] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                     : alphabet_char();
            for (int i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = pat[i];
                hi[8*i +: 8] = pat[i+8];
            end
            pick = $urandom_range(0, 4);
            case (pick)
                0: term = CHAR_LF;
                1: term = CHAR_CR;
                2: term = 8'h00;
                3: term = 8'hFF;
                default: term = 8'($urandom_range(0, 255));
            endcase
            write_reg(REG_TERMINATOR, 64'(term));
            write_reg(REG_TIMEOUT_TICKS, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                                                     : 64'($urandom_range(4, 25)));
            write_reg(REG_GAP_TICKS, ($urandom_range(0, 7) == 0) ? 64'($urandom_range(7, 30))
                                                                 : 64'($urandom_range(1, 6)));
            write_reg(REG_PATTERN_LOW, lo);
            write_reg(REG_PATTERN_HIGH, hi);
            write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(0, PATTERN_MAX)));
        end
    endtask

    task automatic send_line();
        int n;
        int pick;
        int guard;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 8);
        for (int i = 0; i < n && sb.in_wait; i++)
        begin
            pick = $urandom_range(0, 24);
            if (pick == 0)
                send_text("OK");
            else if (pick == 1)
                send_text("ERROR");
            else if (pick == 2)
                send_pattern();
            else if (pick == 3)
                drive_item(KIND_BYTE, ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
            else if (pick == 4)
                drive_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            else if (pick == 5 && $urandom_range(0, 3) == 0)
                drive_item(KIND_START, 8'($urandom_range(0, 255)));
            else
                drive_item(KIND_BYTE, line_byte());
        end
        pick = $urandom_range(0, 3);
        if (pick < 2)
            drive_item(KIND_BYTE, sb.term_byte);
        else if (pick == 2)
        begin
            guard = 0;
            while (sb.in_wait && sb.in_line && guard < 40)
            begin
                drive_item(KIND_TICK, 8'($urandom_range(0, 255)));
                guard++;
            end
        end
    endtask

    task automatic run_wait();
        int lines;
        int guard;
        item_gaps  = ($urandom_range(0, 2) != 0);
        ready_gaps = ($urandom_range(0, 2) != 0);
        for (int i = $urandom_range(0, 2); i > 0; i--)
            drive_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        drive_item(KIND_START, 8'($urandom_range(0, 255)));
        lines = $urandom_range(1, 3);
        for (int j = 0; j < lines && sb.in_wait; j++)
            send_line();
        // Mostly run the wait out; otherwise the next start restarts it.
        if (sb.limit_ticks <= 300 && $urandom_range(0, 4) != 0)
        begin
            guard = 0;
            while (sb.in_wait && guard < 400)
            begin
                drive_item(KIND_TICK, 8'($urandom_range(0, 255)));
                guard++;
            end
        end
    endtask

    initial
    begin
        int phase;
        int unsigned target;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: beats outside a wait, a plain OK, a restart then ERROR.
        drive_item(KIND_BYTE, 8'h41);
        drive_item(KIND_TICK, 8'h00);
        drive_item(KIND_SPARE, 8'hFF);
        drive_item(KIND_START, 8'h00);
        send_text("OK");
        drive_item(KIND_BYTE, CHAR_LF);
        drive_item(KIND_START, 8'h00);
        drive_item(KIND_START, 8'hA5);
        send_text("ERROR");
        drive_item(KIND_BYTE, CHAR_CR);
        drive_item(KIND_BYTE, CHAR_LF);
        settle();

        // Zero timeout, gap of one, pattern "OK" which outranks the OK check.
        write_reg(REG_TERMINATOR, 64'hFF);
        write_reg(REG_TIMEOUT_TICKS, 64'd0);
        write_reg(REG_GAP_TICKS, 64'd1);
        write_reg(REG_PATTERN_LOW, {48'd0, CHAR_K, CHAR_O});
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        drive_item(KIND_START, 8'h00);
        drive_item(KIND_BYTE, 8'h00);
        drive_item(KIND_TICK, 8'h00);
        drive_item(KIND_START, 8'h00);
        drive_item(KIND_TICK, 8'h00);
        drive_item(KIND_START, 8'h00);
        drive_item(KIND_BYTE, 8'hFF);
        drive_item(KIND_START, 8'h00);
        send_text("OK");
        drive_item(KIND_BYTE, 8'hFF);
        settle();

        target     = sb.live_items + RANDOM_ITEMS;
        quiet_from = target - RANDOM_ITEMS / 5;
        phase      = 0;
        while (sb.live_items < target)
        begin
            configure(phase);
            run_wait();
            settle();
            phase++;
        end

        quiet = 1'b1;
        item_valid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_chars.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
